// File: hdl/dcmf_pkg.sv
package dcmf_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int RAD_W = 3;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd7;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_WINDOW_RADIUS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic             pad_item;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] dark_value;
		logic             frame_end;
	} dark_t;

	function automatic logic [PIX_W-1:0] min_u8(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

// File: hdl/dcmf_min_tree.sv
module dcmf_min_tree #(
	parameter int N = 15
) (
	input  logic [7:0]   vals [N],
	input  logic [N-1:0] mask,
	output logic [7:0]   min_val
);
	import dcmf_pkg::*;

	localparam int N2 = 1 << $clog2(N);

	logic [PIX_W-1:0] node [1:2*N2-1];

	always_comb begin
		for (int i = 0; i < N2; i++) begin
			if (i < N) begin
				node[N2+i] = mask[i] ? vals[i] : PIX_MAX;
			end else begin
				node[N2+i] = PIX_MAX;
			end
		end
		for (int i = N2 - 1; i >= 1; i--) begin
			node[i] = min_u8(node[2*i], node[2*i+1]);
		end
	end

	assign min_val = node[1];

endmodule

// File: hdl/dcmf_col_mem.sv
module dcmf_col_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 112
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;
	logic [DW-1:0] last_wr_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
			last_wr_q    <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// a read in the same cycle as a write to that column sees the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? last_wr_q : rd_q;

endmodule

// File: hdl/dcmf_hwin.sv
module dcmf_hwin #(
	parameter int NK = 15
) (
	input  logic          clk,
	input  logic          shift_en,
	input  logic [7:0]    vmin_new,
	input  logic [NK-1:0] hmask,
	output logic [7:0]    hmin
);
	import dcmf_pkg::*;

	localparam int SL = (NK > 1) ? NK - 1 : 1;

	logic [PIX_W-1:0] sr_q [SL];
	logic [PIX_W-1:0] vals [NK];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sr_q[0] <= vmin_new;
			for (int i = 1; i < SL; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	always_comb begin
		vals[0] = vmin_new;
		for (int k = 1; k < NK; k++) begin
			vals[k] = sr_q[k-1];
		end
	end

	dcmf_min_tree #(.N(NK)) u_tree (
		.vals    (vals),
		.mask    (hmask),
		.min_val (hmin)
	);

endmodule

// File: hdl/dcmf_out_fifo.sv
module dcmf_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dcmf_pkg::dark_t   push_data,
	output logic              dark_valid,
	input  logic              dark_ready,
	output dcmf_pkg::dark_t   dark,
	output logic [2:0]        level
);
	import dcmf_pkg::*;

	dark_t      buf_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop        = dark_valid && dark_ready;
	assign dark_valid = (cnt_q != 3'd0);
	assign dark       = buf_q[rd_ptr_q];
	assign level      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// File: hdl/dark_channel_min_filter.sv
// Dark channel minimum filter.
// pix (valid/ready): BGR pixels in raster order, then pad items to drain.
// Each pixel is reduced to min(b,g,r); the output for pixel (r,c) is the
// minimum over rows r-R..r+R and columns c-R..c+R, clipped at the frame.
// The result for a pixel comes with the item R rows and R columns later,
// so R*W+R pad items after the last pixel flush a frame; frame_end marks
// the bottom-right output. Pads that arrive during the pixels are dropped.
// dark (valid/ready): results pass stage 1, stage 2 and the queue.
// Throughput is one item per clock while pix_ready is high; the limit
// is the column history memory, one read and one write per cycle (a
// read of the column written in the same cycle is forwarded).
// A 4-entry output queue absorbs receiver stalls; pix_ready drops only
// when the queue plus items in flight would overflow it.
// Reset (arst_n) clears counters and queue; frame size is 640x480 with
// radius 7. The column memory needs no clearing: stale rows are masked.
// A register write over APB restarts the frame counters.
module dark_channel_min_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  dcmf_pkg::pix_t   pix,
	output logic             dark_valid,
	input  logic             dark_ready,
	output dcmf_pkg::dark_t  dark
);
	import dcmf_pkg::*;

	localparam int NK = 2 * MAX_RADIUS + 1;
	localparam int HD = (MAX_RADIUS > 0) ? 2 * MAX_RADIUS : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int IW = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 1) + 1);

	// configuration
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [RAD_W-1:0] radius_q;
	logic             cfg_wr;
	logic             cfg_hit;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		cfg_hit = 1'b0;
		prdata  = 32'd0;
		unique case (paddr[3:2])
			REG_FRAME_WIDTH: begin
				cfg_hit = 1'b1;
				prdata  = 32'(width_q);
			end
			REG_FRAME_HEIGHT: begin
				cfg_hit = 1'b1;
				prdata  = 32'(height_q);
			end
			REG_WINDOW_RADIUS: begin
				cfg_hit = 1'b1;
				prdata  = 32'(radius_q);
			end
			default: begin
				cfg_hit = 1'b0;
				prdata  = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			radius_q <= RADIUS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_FRAME_WIDTH:   width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT:  height_q <= pwdata[CFG_W-1:0];
				REG_WINDOW_RADIUS: radius_q <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame geometry
	int w_i, h_i, r_i;

	always_comb begin
		if (width_q == '0) w_i = 1;
		else if (int'(width_q) > MAX_WIDTH) w_i = MAX_WIDTH;
		else w_i = int'(width_q);
		if (height_q == '0) h_i = 1;
		else if (int'(height_q) > MAX_HEIGHT) h_i = MAX_HEIGHT;
		else h_i = int'(height_q);
		r_i = (int'(radius_q) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
	end

	// input stage: raster counters
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] lag;
	logic          pixel_phase, take, emit, last;
	logic [7:0]    cur;
	logic [NK-1:0] vmask, hmask;
	logic          occ_ok;
	logic [2:0]    level;
	logic          v_s1, v_s2;

	// idx_q counts items of the frame; outputs start once R*W+R are in
	assign lag         = IW'(r_i * w_i + r_i);
	assign pixel_phase = int'(in_row_q) < h_i;
	assign take        = pix_valid && pix_ready && !(pixel_phase && pix.pad_item);
	assign emit        = idx_q >= lag;
	assign last        = (int'(out_row_q) == h_i - 1) && (int'(out_col_q) == w_i - 1);
	assign cur         = pixel_phase ?
		min_u8(min_u8(pix.blue, pix.green), pix.red) : PIX_MAX;

	assign occ_ok    = (level + 3'(v_s1) + 3'(v_s2)) < 3'd4;
	assign pix_ready = occ_ok;

	// window masks: vertical entry k is row in_row-k, horizontal tap k is
	// column out_col+R-k
	always_comb begin
		for (int k = 0; k < NK; k++) begin
			vmask[k] = (k <= 2 * r_i) && (int'(in_row_q) >= k) &&
				(int'(in_row_q) < h_i + k);
			hmask[k] = (k <= 2 * r_i) && (int'(out_col_q) + r_i >= k) &&
				(int'(out_col_q) + r_i < w_i + k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			idx_q     <= '0;
		end else if (cfg_wr && cfg_hit) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			idx_q     <= '0;
		end else if (take) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				idx_q     <= '0;
			end else begin
				idx_q <= idx_q + IW'(1);
				if (int'(in_col_q) + 1 >= w_i) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit) begin
					if (int'(out_col_q) + 1 >= w_i) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// stage 1: column history read, vertical minimum, write back
	logic          emit_s1, last_s1;
	logic [CW-1:0] col_s1;
	logic [7:0]    cur_s1;
	logic [NK-1:0] vmask_s1, hmask_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= take;
			emit_s1 <= take && emit;
			last_s1 <= take && emit && last;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_s1   <= in_col_q;
			cur_s1   <= cur;
			vmask_s1 <= vmask;
			hmask_s1 <= hmask;
		end
	end

	logic [HD*8-1:0] hist_old, hist_new;
	logic [7:0]      hist_e [HD];
	logic [7:0]      vvals [NK];
	logic [7:0]      vmin;

	dcmf_col_mem #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(HD * 8)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (in_col_q[AW-1:0]),
		.wr_en   (v_s1),
		.wr_addr (col_s1[AW-1:0]),
		.wr_data (hist_new),
		.rd_data (hist_old)
	);

	always_comb begin
		for (int i = 0; i < HD; i++) begin
			hist_e[i] = hist_old[i*8 +: 8];
		end
		hist_new[7:0] = cur_s1;
		for (int i = 1; i < HD; i++) begin
			hist_new[i*8 +: 8] = hist_e[i-1];
		end
		vvals[0] = cur_s1;
		for (int k = 1; k < NK; k++) begin
			vvals[k] = hist_e[k-1];
		end
	end

	dcmf_min_tree #(.N(NK)) u_vtree (
		.vals    (vvals),
		.mask    (vmask_s1),
		.min_val (vmin)
	);

	// stage 2: horizontal window
	logic          emit_s2, last_s2;
	logic [7:0]    vmin_s2;
	logic [NK-1:0] hmask_s2;
	logic [7:0]    hmin;
	dark_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			emit_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			vmin_s2  <= vmin;
			hmask_s2 <= hmask_s1;
		end
	end

	dcmf_hwin #(.NK(NK)) u_hwin (
		.clk      (clk),
		.shift_en (v_s2),
		.vmin_new (vmin_s2),
		.hmask    (hmask_s2),
		.hmin     (hmin)
	);

	assign res.dark_value = hmin;
	assign res.frame_end  = last_s2;

	dcmf_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (emit_s2),
		.push_data  (res),
		.dark_valid (dark_valid),
		.dark_ready (dark_ready),
		.dark       (dark),
		.level      (level)
	);

endmodule

// File: bench/dcmf_checker.sv
module dcmf_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	input  logic            pready,
	input  logic            pix_valid,
	input  logic            pix_ready,
	input  dcmf_pkg::pix_t  pix,
	input  logic            dark_valid,
	input  logic            dark_ready,
	input  dcmf_pkg::dark_t dark,
	output int              errors,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import dcmf_pkg::*;

	localparam int LINE_MAX = 1024;
	localparam int ROWS_MAX = 1024;
	localparam int RAD_MAX  = 7;
	localparam int RING     = 3 * RAD_MAX + 2;

	bit [PIX_W-1:0] minima [0:RING*LINE_MAX-1];
	logic [CFG_W-1:0] width_reg, height_reg;
	logic [RAD_W-1:0] radius_reg;
	int in_col, in_row, out_col, out_row;
	dark_t dark_expected [$];

	assign pending = dark_expected.size();

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		return (width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg == 0) return 1;
		return (height_reg > ROWS_MAX) ? ROWS_MAX : int'(height_reg);
	endfunction

	function automatic bit [PIX_W-1:0] window_floor(int r, int c, int w, int h, int rad);
		int r0, r1, c0, c1;
		bit [PIX_W-1:0] m;
		r0 = (r > rad) ? r - rad : 0;
		r1 = (r + rad < h) ? r + rad : h - 1;
		c0 = (c > rad) ? c - rad : 0;
		c1 = (c + rad < w) ? c + rad : w - 1;
		m = PIX_MAX;
		for (int i = r0; i <= r1; i++)
			for (int j = c0; j <= c1; j++)
				if (minima[(i % RING) * LINE_MAX + j] < m)
					m = minima[(i % RING) * LINE_MAX + j];
		return m;
	endfunction

	task automatic take_pixel(input pix_t p);
		int w, h, rad, idx, lag;
		bit [PIX_W-1:0] m;
		dark_t e;
		bit last;
		w = eff_width();
		h = eff_height();
		rad = int'(radius_reg);
		if (in_row < h) begin
			if (p.pad_item)
				return;
			m = p.blue;
			if (p.green < m) m = p.green;
			if (p.red < m) m = p.red;
			minima[(in_row % RING) * LINE_MAX + in_col] = m;
		end
		idx = in_row * w + in_col;
		lag = rad * w + rad;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (idx >= lag) begin
			last = (out_row == h - 1) && (out_col == w - 1);
			e.dark_value = window_floor(out_row, out_col, w, h, rad);
			e.frame_end = last;
			dark_expected.push_back(e);
			if (last) begin
				in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			radius_reg = RADIUS_RESET;
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_FRAME_WIDTH: width_reg = pwdata[CFG_W-1:0];
					REG_FRAME_HEIGHT: height_reg = pwdata[CFG_W-1:0];
					REG_WINDOW_RADIUS: radius_reg = pwdata[RAD_W-1:0];
					default: ;
				endcase
				in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			end
			if (pix_valid && pix_ready)
				take_pixel(pix);
			if (dark_valid && dark_ready) begin
				if (dark_expected.size() == 0) begin
					$display("%0t: unexpected item dark_value=%0d frame_end=%0b",
						$time, dark.dark_value, dark.frame_end);
					errors++;
				end else begin
					dark_t e;
					e = dark_expected.pop_front();
					if (dark.dark_value !== e.dark_value) begin
						$display("%0t: dark_value expected %0d actual %0d",
							$time, e.dark_value, dark.dark_value);
						errors++;
					end
					if (dark.frame_end !== e.frame_end) begin
						$display("%0t: frame_end expected %0b actual %0b",
							$time, e.frame_end, dark.frame_end);
						errors++;
					end
				end
			end
		end
	end
endmodule

// File: bench/tb_dark_channel_min_filter.sv
module tb_dark_channel_min_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import dcmf_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic pix_valid = 0;
	logic pix_ready;
	pix_t pix = '0;
	logic dark_valid;
	logic dark_ready = 0;
	dark_t dark;
	int errors, pending;

	bit hold_req = 0;
	bit held = 0;
	bit quiet = 0;
	bit quieted = 0;
	int rand_items = 0;
	bit counting = 0;

	always #1 clk = ~clk;

	dark_channel_min_filter dut (.*);

	dcmf_checker chk (.*);

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				dark_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else begin
				dark_ready <= !arst_n ? 1'b0 : (quiet || $urandom_range(0, 99) >= 6);
			end
		end
	end

	task automatic offer(input pix_t p);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			pix_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pix_valid <= 1;
		pix <= p;
		do @(posedge clk); while (!pix_ready);
	endtask

	function automatic logic [PIX_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return PIX_MAX;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic pix_t rand_pixel(bit pad);
		pix_t p;
		p.pad_item = pad;
		p.blue = rand_chan();
		p.green = rand_chan();
		p.red = rand_chan();
		return p;
	endfunction

	task automatic wait_drained();
		pix_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input int value);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic configure(input int w, input int h, input int r);
		wait_drained();
		reg_write(REG_FRAME_WIDTH, w);
		reg_write(REG_FRAME_HEIGHT, h);
		reg_write(REG_WINDOW_RADIUS, r);
	endtask

	// one frame of pixels then drain; cut short after stop_at items if >= 0
	task automatic run_frame(input int w, input int h, input int r, input int stop_at);
		int total, sent;
		total = w * h + r * w + r;
		sent = 0;
		while (sent < total && sent != stop_at) begin
			if (sent < w * h && $urandom_range(0, 99) < 3) begin
				offer(rand_pixel(1));  // ignored pad inside the frame
			end else begin
				offer(rand_pixel(sent >= w * h ? ($urandom_range(0, 99) >= 20) : 1'b0));
				sent++;
				if (counting) rand_items++;
			end
		end
	endtask

	initial begin
		int w, h, r;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (4) @(posedge clk);

		// reset-value frame setting is large; shrink first
		configure(4, 3, 1);
		run_frame(4, 3, 1, -1);
		offer(rand_pixel(1));
		run_frame(4, 3, 1, -1);
		configure(0, 0, 0);
		run_frame(1, 1, 0, -1);
		run_frame(1, 1, 0, -1);
		configure(3, 2, 7);
		run_frame(3, 2, 7, -1);
		configure(2047, 1, 0);
		run_frame(1024, 1, 0, -1);
		configure(1, 2047, 7);
		run_frame(1, 1024, 7, 60);   // tall frame, cut short
		configure(5, 4, 2);
		run_frame(5, 4, 2, 9);   // abandoned by the next write
		configure(5, 4, 2);
		run_frame(5, 4, 2, -1);

		counting = 1;
		while (rand_items < 650) begin
			w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 24);
			h = $urandom_range(1, 10);
			r = $urandom_range(0, 7);
			configure(w, h, r);
			quiet = (rand_items > 300 && !quieted);
			if (quiet)
				quieted = 1;
			if (rand_items > 100 && !held) begin
				hold_req = 1;
				held = 1;
			end
			if ($urandom_range(0, 9) == 0) begin
				run_frame(w, h, r, $urandom_range(0, w * h + r * w + r));
			end else begin
				repeat ($urandom_range(1, 2)) run_frame(w, h, r, -1);
			end
		end
		quiet = 0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: sim.f
hdl/dcmf_pkg.sv
hdl/dcmf_min_tree.sv
hdl/dcmf_col_mem.sv
hdl/dcmf_hwin.sv
hdl/dcmf_out_fifo.sv
hdl/dark_channel_min_filter.sv
bench/dcmf_checker.sv
bench/tb_dark_channel_min_filter.sv
